// ----- hdl/mpp_pkg.sv -----
// Shared types and constants for the monotone peak picker.
`default_nettype none

package mpp_pkg;

    // Sample geometry.
    localparam int DIMS        = 6;
    localparam int SAMPLE_BITS = 32;
    localparam int DIM_BITS    = 3;

    // Three rising differences before a peak and three falling ones after it.
    localparam int LAG        = 3;
    localparam int MARK_CELLS = 2 * LAG - 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [DIMS-1:0]            t_vec;

    // Input request: one trajectory sample.
    typedef struct packed {
        logic    traj_start;
        t_sample comp_0;
        t_sample comp_1;
        t_sample comp_2;
        t_sample comp_3;
        t_sample comp_4;
        t_sample comp_5;
    } t_in_req;

    // Output request: one peak sample.
    typedef struct packed {
        t_sample peak_0;
        t_sample peak_1;
        t_sample peak_2;
        t_sample peak_3;
        t_sample peak_4;
        t_sample peak_5;
    } t_out_req;

    // Direction of one difference in the watched component.
    typedef struct packed {
        logic rise;
        logic fall;
    } t_mark;

endpackage

`default_nettype wire

// ----- hdl/mpp_cell.sv -----
// One cell of the difference-mark chain: holds the direction of one difference.
`default_nettype none

module mpp_cell
    import mpp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire logic  i_clr,
    input  wire t_mark i_mark,
    output t_mark      o_mark
);

    t_mark r_mark;
    t_mark n_mark;

    // Take the neighbour's mark on every accepted sample; a new trajectory clears it.
    always_comb begin
        n_mark = r_mark;
        if (i_adv) begin
            if (i_clr) begin
                n_mark = '0;
            end else begin
                n_mark = i_mark;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
        end else begin
            r_mark <= n_mark;
        end
    end

    assign o_mark = r_mark;

endmodule

`default_nettype wire

// ----- hdl/mpp_delay.sv -----
// Delay line holding the last few sample vectors.
`default_nettype none

module mpp_delay
    import mpp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_adv,
    input  wire t_vec i_vec,
    output t_vec      o_tap
);

    t_vec r_stage [LAG];

    // Shift the vectors along by one place per accepted sample.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage[0] <= i_vec;
            for (int k = 1; k < LAG; k++) begin
                r_stage[k] <= r_stage[k-1];
            end
        end
    end

    assign o_tap = r_stage[LAG-1];

endmodule

`default_nettype wire

// ----- hdl/monotone_peak_picker.sv -----
// Top level of the monotone peak picker.
//
// Samples enter on the input channel (i_in_valid, o_in_stall, i_in) and peak
// vectors leave on the output channel (o_out_valid, i_out_stall, o_out). A
// request moves when valid is high and stall is low. The watched component is
// set through i_cfg_wr_en and i_cfg_wr_data; the user must set it only while
// the block is idle, as the block itself does not enforce this. A sample is a
// peak when the watched component rose over the three differences before it and
// fell over the three after it; its vector is shown in the cycle after the third
// following sample is accepted. One sample is accepted every cycle while the
// input is not stalled: each sample moves the row of mark cells and the three-deep
// vector delay line along by one place, and the peak test is a single compare
// plus an AND of five stored marks. The output register parts the two channels,
// so the input stalls only when a peak waits in it while the receiver stalls.
// Reset clears the marks, the output valid and the register to component 0,
// and starts a trajectory; a set traj_start begins a new one.
`default_nettype none

module monotone_peak_picker
    import mpp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [DIM_BITS-1:0] i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_req             i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_req                 o_out
);

    logic [DIM_BITS-1:0] r_tracked_dim;
    logic                r_primed;
    t_sample             r_last;
    logic                r_out_valid;
    t_out_req            r_out;

    logic                w_in_acc;
    logic                w_start;
    logic [DIM_BITS-1:0] w_sel;
    t_vec                w_cur;
    t_sample             w_cur_sel;
    logic                w_up;
    logic                w_down;
    logic                w_peak;
    t_vec                w_tap;
    t_mark               w_chain_in [MARK_CELLS];
    t_mark               w_mark     [MARK_CELLS];
    logic [MARK_CELLS-1:0] w_rise;
    logic [MARK_CELLS-1:0] w_fall;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_start    = i_in.traj_start;

    // Unpack the sample into a vector.
    always_comb begin
        w_cur[0] = i_in.comp_0;
        w_cur[1] = i_in.comp_1;
        w_cur[2] = i_in.comp_2;
        w_cur[3] = i_in.comp_3;
        w_cur[4] = i_in.comp_4;
        w_cur[5] = i_in.comp_5;
    end

    // An index past the last component saturates to the last one.
    assign w_sel = (r_tracked_dim >= DIM_BITS'(DIMS)) ? DIM_BITS'(DIMS - 1) : r_tracked_dim;
    assign w_cur_sel = w_cur[w_sel];

    // Direction of this difference; the first sample of a trajectory gives none.
    assign w_up   = r_primed && !w_start && ($signed(w_cur_sel) > $signed(r_last));
    assign w_down = r_primed && !w_start && ($signed(w_cur_sel) < $signed(r_last));

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked_dim <= '0;
        end else if (i_cfg_wr_en) begin
            r_tracked_dim <= i_cfg_wr_data;
        end
    end

    // Previous watched value and whether it belongs to this trajectory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (w_in_acc) begin
            r_primed <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_last <= w_cur_sel;
        end
    end

    // Row of mark cells, newest difference in cell 0.
    assign w_chain_in[0] = '{rise: w_up, fall: w_down};

    for (genvar k = 0; k < MARK_CELLS; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign w_chain_in[k] = w_mark[k-1];
        end
        mpp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_in_acc),
            .i_clr   (w_start),
            .i_mark  (w_chain_in[k]),
            .o_mark  (w_mark[k])
        );
        assign w_rise[k] = w_mark[k].rise;
        assign w_fall[k] = w_mark[k].fall;
    end

    // Vector delay line; its tap is the candidate peak sample.
    mpp_delay u_delay (
        .i_clk (i_clk),
        .i_adv (w_in_acc),
        .i_vec (w_cur),
        .o_tap (w_tap)
    );

    // Peak test on the marks as they will stand after this sample.
    always_comb begin
        w_peak = !w_start && w_down;
        for (int k = 0; k < LAG; k++) begin
            w_peak = w_peak && w_rise[LAG - 1 + k];
        end
        for (int k = 0; k < LAG - 1; k++) begin
            w_peak = w_peak && w_fall[k];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc && w_peak) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_peak) begin
            r_out.peak_0 <= w_tap[0];
            r_out.peak_1 <= w_tap[1];
            r_out.peak_2 <= w_tap[2];
            r_out.peak_3 <= w_tap[3];
            r_out.peak_4 <= w_tap[4];
            r_out.peak_5 <= w_tap[5];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // A difference is never marked as both rising and falling.
    a_mark_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rise & w_fall) == '0)
        else $error("mark cell holds both rise and fall");

    // Until a first sample is seen, no difference has been marked.
    a_unprimed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (w_rise == '0) && (w_fall == '0))
        else $error("marks set before any sample");

    // A sample that starts a trajectory leaves no mark in the newest cell.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_start |=> r_primed && !w_rise[0] && !w_fall[0])
        else $error("trajectory start left a mark");

    // A detected peak is presented on the next cycle.
    a_peak_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_peak |=> o_out_valid)
        else $error("peak not presented");
`endif

endmodule

`default_nettype wire
